### rtl/tncg_pkg.sv
package tncg_pkg;

	// chime timing, in samples
	localparam int unsigned NOTE_LENGTH  = 1600;
	localparam int unsigned GAP_LENGTH   = 480;
	localparam int unsigned TOTAL_LENGTH = 4096;
	localparam int unsigned SAMPLE_RATE  = 16000;
	localparam int unsigned NOTE1_START  = NOTE_LENGTH + GAP_LENGTH;
	localparam int unsigned NOTE1_END    = NOTE1_START + NOTE_LENGTH;

	// envelope and amplitude
	localparam int unsigned AMP_RESET   = 5200;
	localparam int unsigned ATTACK_LEN  = 32;
	localparam int unsigned RELEASE_LEN = 64;
	localparam int unsigned FULL_GAIN   = 256;
	localparam int unsigned ATTACK_STEP = FULL_GAIN / ATTACK_LEN;
	localparam int unsigned RELEASE_STEP = FULL_GAIN / RELEASE_LEN;
	localparam int unsigned GAIN_SHIFT  = $clog2(FULL_GAIN);

	// field and state widths
	localparam int unsigned MODE_W   = 1;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned CHIME_W  = 2;
	localparam int unsigned POS_W    = 13;
	localparam int unsigned PHASE_W  = 16;
	localparam int unsigned AMP_W    = 15;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned FREQ_W   = 11;
	localparam int unsigned GAIN_W   = $clog2(FULL_GAIN + 1);
	localparam int unsigned NUM_CHIMES = 4;

	// item modes
	localparam logic [MODE_W-1:0] MODE_TICK  = 1'b0;
	localparam logic [MODE_W-1:0] MODE_START = 1'b1;

	typedef enum logic [CHIME_W-1:0] {
		CHIME_UP,
		CHIME_DOWN,
		CHIME_OK,
		CHIME_BACK
	} chime_t;

	typedef logic [FREQ_W-1:0] freq_t;

	// note frequency in Hz for a chime, first or second note
	function automatic freq_t note_freq(input chime_t chime, input logic second);
		freq_t f;
		case (chime)
			CHIME_UP:   f = second ? freq_t'(1175) : freq_t'(880);
			CHIME_DOWN: f = second ? freq_t'(880)  : freq_t'(1175);
			CHIME_OK:   f = second ? freq_t'(1480) : freq_t'(988);
			CHIME_BACK: f = second ? freq_t'(523)  : freq_t'(740);
			default:    f = '0;
		endcase
		return f;
	endfunction

endpackage

### rtl/tncg_in_if.sv
interface tncg_in_if;
	logic                          valid;
	logic                          ready;
	logic [tncg_pkg::MODE_W-1:0]   mode;
	logic [tncg_pkg::KIND_W-1:0]   kind;

	modport source (output valid, output mode, output kind, input ready);
	modport sink   (input valid, input mode, input kind, output ready);
endinterface

### rtl/tncg_out_if.sv
interface tncg_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [tncg_pkg::SAMPLE_W-1:0] sample;
	logic                                active;
	logic                                last;
	logic                                rejected;

	modport source (output valid, output sample, output active, output last,
		output rejected, input ready);
	modport sink   (input valid, input sample, input active, input last,
		input rejected, output ready);
endinterface

### rtl/two_note_chime_generator.sv
// channel   dir  handshake      payload
// item      in   valid/ready    mode[0:0], kind[2:0]
// result    out  valid/ready    sample[15:0] signed, active, last, rejected
// wr        in   wr_en          wr_data[14:0] = peak amplitude at full gain
//
// one transaction per cycle sustained while result is not stalled; a result is registered through
// the input register, the envelope/phase stage and the multiply stage
// the phase and position update sits in the second stage, once per transaction
// arst_n clears the pipeline valids, the chime state and sets amplitude to 5200
// a stall on result fills the empty stages before item.ready drops
module two_note_chime_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	tncg_in_if.sink                        item,
	tncg_out_if.source                     result,
	input  logic                           wr_en,
	input  logic [tncg_pkg::AMP_W-1:0]     wr_data
);

	typedef struct packed {
		logic [tncg_pkg::GAIN_W-1:0] gain;
		logic                        neg;
		logic                        sound;
		logic                        active;
		logic                        last;
		logic                        rejected;
	} s2_t;

	// stage registers
	logic                            valid_s1, valid_s2, valid_s3;
	logic [tncg_pkg::MODE_W-1:0]     mode_s1;
	logic [tncg_pkg::KIND_W-1:0]     kind_s1;
	s2_t                             st_s2;
	logic signed [tncg_pkg::SAMPLE_W-1:0] sample_s3;
	logic                            active_s3, last_s3, rejected_s3;

	// chime state
	logic                            playing_q;
	tncg_pkg::chime_t                chime_q;
	logic [tncg_pkg::POS_W-1:0]      position_q;
	logic [tncg_pkg::PHASE_W-1:0]    phase_q;
	logic [tncg_pkg::AMP_W-1:0]      amp_q;

	logic ready_s1, ready_s2, ready_s3;
	logic adv1;

	logic                            is_start, kind_ok, is_tick;
	logic                            in_note0, in_note1, pos_last;
	logic [tncg_pkg::POS_W-1:0]      idx, remaining;
	tncg_pkg::freq_t                 freq;
	logic [tncg_pkg::PHASE_W-1:0]    phase_base, phase_next;
	logic [tncg_pkg::PHASE_W:0]      phase_sum;
	logic [tncg_pkg::GAIN_W-1:0]     gain_att, gain_rel, gain;
	s2_t                             st_next;

	logic [tncg_pkg::AMP_W+tncg_pkg::GAIN_W-1:0] product;
	logic [tncg_pkg::SAMPLE_W-1:0]   mag;
	logic signed [tncg_pkg::SAMPLE_W-1:0] sample_next;

	// backpressure chain
	assign ready_s3   = !valid_s3 || result.ready;
	assign ready_s2   = !valid_s2 || ready_s3;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign item.ready = ready_s1;
	assign adv1       = valid_s1 && ready_s2;

	// decode of the registered item
	assign is_start = (mode_s1 == tncg_pkg::MODE_START);
	assign is_tick  = (mode_s1 == tncg_pkg::MODE_TICK);
	assign kind_ok  = (kind_s1 < tncg_pkg::KIND_W'(tncg_pkg::NUM_CHIMES));

	// where in the chime we are
	assign in_note0 = (32'(position_q) < tncg_pkg::NOTE_LENGTH);
	assign in_note1 = (32'(position_q) >= tncg_pkg::NOTE1_START) &&
		(32'(position_q) < tncg_pkg::NOTE1_END);
	assign pos_last = (32'(position_q) + 32'd1 >= tncg_pkg::TOTAL_LENGTH);
	assign idx = in_note0 ? position_q :
		position_q - tncg_pkg::POS_W'(tncg_pkg::NOTE1_START);

	// phase accumulator, cleared on a note's first sample, wraps at sample rate
	assign freq       = tncg_pkg::note_freq(chime_q, in_note1);
	assign phase_base = (idx == '0) ? '0 : phase_q;
	assign phase_sum  = {1'b0, phase_base} + (tncg_pkg::PHASE_W+1)'(freq);
	always_comb begin
		if (phase_sum >= (tncg_pkg::PHASE_W+1)'(tncg_pkg::SAMPLE_RATE)) begin
			phase_next = tncg_pkg::PHASE_W'(phase_sum -
				(tncg_pkg::PHASE_W+1)'(tncg_pkg::SAMPLE_RATE));
		end else begin
			phase_next = phase_sum[tncg_pkg::PHASE_W-1:0];
		end
	end

	// envelope: attack ramp, flat top, release ramp
	assign remaining = tncg_pkg::POS_W'(tncg_pkg::NOTE_LENGTH - 1) - idx;
	assign gain_att = (32'(idx) < tncg_pkg::ATTACK_LEN) ?
		tncg_pkg::GAIN_W'(32'(idx) * tncg_pkg::ATTACK_STEP) :
		tncg_pkg::GAIN_W'(tncg_pkg::FULL_GAIN);
	assign gain_rel = (32'(remaining) < tncg_pkg::RELEASE_LEN) ?
		tncg_pkg::GAIN_W'(32'(remaining) * tncg_pkg::RELEASE_STEP) :
		tncg_pkg::GAIN_W'(tncg_pkg::FULL_GAIN);
	assign gain = (gain_rel < gain_att) ? gain_rel : gain_att;

	// second stage payload
	always_comb begin
		st_next.gain     = gain;
		st_next.neg      = (phase_next >=
			tncg_pkg::PHASE_W'(tncg_pkg::SAMPLE_RATE / 2));
		st_next.active   = is_tick && playing_q;
		st_next.sound    = is_tick && playing_q && (in_note0 || in_note1);
		st_next.last     = is_tick && playing_q && pos_last;
		st_next.rejected = is_start && !kind_ok;
	end

	// amplitude register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q <= tncg_pkg::AMP_W'(tncg_pkg::AMP_RESET);
		end else if (wr_en) begin
			amp_q <= wr_data;
		end
	end

	// chime state update, once per transaction leaving stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q  <= 1'b0;
			chime_q    <= tncg_pkg::CHIME_UP;
			position_q <= '0;
			phase_q    <= '0;
		end else if (adv1) begin
			if (is_start && kind_ok) begin
				playing_q  <= 1'b1;
				chime_q    <= tncg_pkg::chime_t'(kind_s1[tncg_pkg::CHIME_W-1:0]);
				position_q <= '0;
				phase_q    <= '0;
			end else if (is_tick && playing_q) begin
				if (in_note0 || in_note1) begin
					phase_q <= phase_next;
				end
				if (pos_last) begin
					playing_q  <= 1'b0;
					position_q <= '0;
				end else begin
					position_q <= position_q + tncg_pkg::POS_W'(1);
				end
			end
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= item.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// scaled square wave
	assign product = (tncg_pkg::AMP_W+tncg_pkg::GAIN_W)'(amp_q) *
		(tncg_pkg::AMP_W+tncg_pkg::GAIN_W)'(st_s2.gain);
	assign mag = tncg_pkg::SAMPLE_W'(product >> tncg_pkg::GAIN_SHIFT);
	always_comb begin
		if (!st_s2.sound) begin
			sample_next = '0;
		end else if (st_s2.neg) begin
			sample_next = -$signed(mag);
		end else begin
			sample_next = $signed(mag);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item.valid && ready_s1) begin
			mode_s1 <= item.mode;
			kind_s1 <= item.kind;
		end
		if (adv1) begin
			st_s2 <= st_next;
		end
		if (valid_s2 && ready_s3) begin
			sample_s3   <= sample_next;
			active_s3   <= st_s2.active;
			last_s3     <= st_s2.last;
			rejected_s3 <= st_s2.rejected;
		end
	end

	assign result.valid    = valid_s3;
	assign result.sample   = sample_s3;
	assign result.active   = active_s3;
	assign result.last     = last_s3;
	assign result.rejected = rejected_s3;

endmodule

### rtl/tncg_checker.sv
module tncg_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic signed [tncg_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 active,
	input  logic                                 last,
	input  logic                                 rejected
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample) &&
		$stable(active) && $stable(last) && $stable(rejected))
		else $error("result changed while stalled");

	// a rejected start carries nothing else
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> !active && !last && (sample == '0))
		else $error("rejected result not empty");

	// the final sample belongs to a playing chime
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> active)
		else $error("last without active");

	// idle and start results are silent
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active |-> (sample == '0))
		else $error("nonzero sample while not active");

endmodule

bind two_note_chime_generator tncg_checker u_tncg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.sample    (result.sample),
	.active    (result.active),
	.last      (result.last),
	.rejected  (result.rejected)
);
